// ===== rtl/core/sv39pm_pkg.sv =====
// ----------------------------------------------------------------------------
// sv39pm_pkg
// Shared widths, status codes and the leaf flag encoder of the Sv39 mapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sv39pm_pkg;

  localparam int POOL_PAGES_DEF = 8;
  localparam int VA_BITS_DEF    = 38;

  localparam int VPN_W   = 27;
  localparam int PPN_W   = 44;
  localparam int ENTRY_W = 54;
  localparam int IDX_W   = 9;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 64;

  // Result status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_ROOT  = 3'd1;
  localparam logic [2:0] ST_TOO_HIGH = 3'd2;
  localparam logic [2:0] ST_NO_POOL  = 3'd3;
  localparam logic [2:0] ST_CONFLICT = 3'd4;

  // Register indexes.
  localparam logic REG_ROOT = 1'b0;
  localparam logic REG_POOL = 1'b1;

  // Entry flag bits.
  localparam logic [7:0] F_V = 8'h01;
  localparam logic [7:0] F_R = 8'h02;
  localparam logic [7:0] F_W = 8'h04;
  localparam logic [7:0] F_X = 8'h08;
  localparam logic [7:0] F_U = 8'h10;
  localparam logic [7:0] F_A = 8'h40;
  localparam logic [7:0] F_D = 8'h80;

  // Turns protection bits and the user flag into leaf flags, valid included.
  function automatic logic [7:0] leaf_flags(input logic [2:0] prot, input logic user);
    logic [7:0] f;
    f = 8'h00;
    if (prot[0]) f = f | F_R | F_A;
    if (prot[1]) f = f | F_W | F_D;
    if (prot[2]) f = f | F_X | F_A;
    if (f == 8'h00) f = F_R;
    if (user) f = f | F_U;
    return f | F_V;
  endfunction

endpackage

// ===== rtl/core/sv39pm_if.sv =====
// ----------------------------------------------------------------------------
// sv39pm_req_if / sv39pm_rsp_if
// Valid/ready channels for map requests and their results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sv39pm_req_if;
  logic                       valid;
  logic                       ready;
  logic [sv39pm_pkg::VPN_W-1:0] virt_page;
  logic [sv39pm_pkg::PPN_W-1:0] phys_page;
  logic [2:0]                 prot_bits;
  logic                       user_access;

  modport source (output valid, virt_page, phys_page, prot_bits, user_access,
                  input ready);
  modport sink   (input valid, virt_page, phys_page, prot_bits, user_access,
                  output ready);
endinterface

interface sv39pm_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     status;
  logic [sv39pm_pkg::ENTRY_W-1:0] leaf_entry;
  logic                           perm_updated;

  modport source (output valid, status, leaf_entry, perm_updated, input ready);
  modport sink   (input valid, status, leaf_entry, perm_updated, output ready);
endinterface

// ===== rtl/core/sv39pm_table_mem.sv =====
// ----------------------------------------------------------------------------
// sv39pm_table_mem
// Page table store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sv39pm_table_mem #(
  parameter int POOL_PAGES = sv39pm_pkg::POOL_PAGES_DEF,
  parameter int MA_W       = $clog2(POOL_PAGES + 1) + sv39pm_pkg::IDX_W
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [MA_W-1:0]                wr_addr,
  input  logic [sv39pm_pkg::ENTRY_W-1:0] wr_data,
  input  logic [MA_W-1:0]                rd_addr,
  output logic [sv39pm_pkg::ENTRY_W-1:0] rd_data
);

  localparam int DEPTH = (POOL_PAGES + 1) << sv39pm_pkg::IDX_W;

  logic [sv39pm_pkg::ENTRY_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // Read port, registered data.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/sv39_page_map_engine.sv =====
// ----------------------------------------------------------------------------
// sv39_page_map_engine
// Maps one 4 KiB virtual page per request in an internal Sv39 page table.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake      Payload
// req      in   valid/ready    virt_page, phys_page, prot_bits, user_access
// rsp      out  valid/ready    status, leaf_entry, perm_updated
// apb      in   psel/penable   paddr, pwdata, prdata (64-bit registers at 0, 8)
//
// After reset a pass clears the root table; requests wait for it.
// A request reads one entry per level (3 levels) through S_LOOK and S_EVAL,
// plus a clearing pass for each pool page it allocates and clears; the store's single write port sets this.
// Early rejections set their result straight from the idle state. A new request is taken once the
// previous result transfer has completed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sv39_page_map_engine #(
  parameter int POOL_PAGES = sv39pm_pkg::POOL_PAGES_DEF,
  parameter int VA_BITS    = sv39pm_pkg::VA_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sv39pm_pkg::ADDR_W-1:0] paddr,
  input  logic [sv39pm_pkg::DATA_W-1:0] pwdata,
  output logic [sv39pm_pkg::DATA_W-1:0] prdata,
  output logic                          pready,
  sv39pm_req_if.sink                    req,
  sv39pm_rsp_if.source                  rsp
);

  localparam int PG_W   = $clog2(POOL_PAGES + 1);
  localparam int IDX_W  = sv39pm_pkg::IDX_W;
  localparam int MA_W   = PG_W + IDX_W;
  localparam int PPN_W  = sv39pm_pkg::PPN_W;
  localparam int VPN_W  = sv39pm_pkg::VPN_W;
  localparam int VPN_OK = VA_BITS - 12;

  typedef enum logic [2:0] {S_INIT, S_IDLE, S_LOOK, S_EVAL, S_CLR} state_t;

  state_t                         state;
  logic [PPN_W-1:0]               root_ppn;
  logic [PPN_W-1:0]               pool_ppn;
  logic [PG_W-1:0]                nfree;
  logic [PG_W-1:0]                page;
  logic [1:0]                     level;
  logic [IDX_W-1:0]               clr_idx;
  logic [VPN_W-1:0]               vpn;
  logic [PPN_W-1:0]               ppn;
  logic [7:0]                     flags;
  logic                           out_valid;
  logic [2:0]                     out_status;
  logic [sv39pm_pkg::ENTRY_W-1:0] out_leaf;
  logic                           out_upd;

  logic                           wr_en;
  logic [MA_W-1:0]                wr_addr;
  logic [sv39pm_pkg::ENTRY_W-1:0] wr_data;
  logic [MA_W-1:0]                slot;
  logic [sv39pm_pkg::ENTRY_W-1:0] rd_data;
  logic [IDX_W-1:0]               idx;
  logic [PPN_W-1:0]               e_ppn;
  logic [PPN_W-1:0]               k;
  logic                           k_ok;
  logic                           pool_full;
  logic [sv39pm_pkg::ENTRY_W-1:0] leaf;
  logic                           cfg_wr;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_ppn <= '0;
      pool_ppn <= '0;
    end else if (cfg_wr) begin
      case (paddr[3])
        sv39pm_pkg::REG_ROOT: root_ppn <= pwdata[PPN_W-1:0];
        sv39pm_pkg::REG_POOL: pool_ppn <= pwdata[PPN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      sv39pm_pkg::REG_ROOT: prdata = {{(64 - PPN_W){1'b0}}, root_ppn};
      sv39pm_pkg::REG_POOL: prdata = {{(64 - PPN_W){1'b0}}, pool_ppn};
      default:              prdata = '0;
    endcase
  end

  // Walk address: index bits of the current level within the current page.
  always_comb begin
    case (level)
      2'd2:    idx = vpn[26:18];
      2'd1:    idx = vpn[17:9];
      default: idx = vpn[8:0];
    endcase
  end
  assign slot = {page, idx};

  // Decode of the entry just read.
  assign e_ppn     = rd_data[sv39pm_pkg::ENTRY_W-1:10];
  assign k         = e_ppn - pool_ppn;
  assign k_ok      = k < {{(PPN_W - PG_W){1'b0}}, nfree};
  assign pool_full = nfree == PG_W'(POOL_PAGES);
  assign leaf      = {ppn, 2'b00, flags};

  // Store write port.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot;
    wr_data = leaf;
    case (state)
      S_INIT, S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = {page, clr_idx};
        wr_data = '0;
      end
      S_EVAL: begin
        if (level != 2'd0) begin
          wr_en   = !rd_data[0] && !pool_full;
          wr_data = {pool_ppn + {{(PPN_W - PG_W){1'b0}}, nfree}, 10'h001};
        end else begin
          wr_en = !(rd_data[0] && e_ppn != ppn);
        end
      end
      default: ;
    endcase
  end

  sv39pm_table_mem #(
    .POOL_PAGES (POOL_PAGES),
    .MA_W       (MA_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (slot),
    .rd_data (rd_data)
  );

  assign req.ready        = (state == S_IDLE) && !out_valid;
  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.leaf_entry   = out_leaf;
  assign rsp.perm_updated = out_upd;

  // Walk sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      page      <= '0;
      clr_idx   <= '0;
      nfree     <= '0;
      level     <= 2'd2;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) out_valid <= 1'b0;
      case (state)
        S_INIT: begin
          clr_idx <= clr_idx + 1'b1;
          if (&clr_idx) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid && req.ready) begin
            vpn   <= req.virt_page;
            ppn   <= req.phys_page;
            flags <= sv39pm_pkg::leaf_flags(req.prot_bits, req.user_access);
            page  <= '0;
            level <= 2'd2;
            if (root_ppn == '0) begin
              out_valid  <= 1'b1;
              out_status <= sv39pm_pkg::ST_NO_ROOT;
              out_leaf   <= '0;
              out_upd    <= 1'b0;
            end else if ((req.virt_page >> VPN_OK) != '0) begin
              out_valid  <= 1'b1;
              out_status <= sv39pm_pkg::ST_TOO_HIGH;
              out_leaf   <= '0;
              out_upd    <= 1'b0;
            end else begin
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: state <= S_EVAL;
        S_EVAL: begin
          if (level != 2'd0) begin
            if (rd_data[0]) begin
              if (k_ok) begin
                page  <= k[PG_W-1:0] + 1'b1;
                level <= level - 1'b1;
                state <= S_LOOK;
              end else begin
                out_valid  <= 1'b1;
                out_status <= sv39pm_pkg::ST_NO_POOL;
                out_leaf   <= '0;
                out_upd    <= 1'b0;
                state      <= S_IDLE;
              end
            end else if (pool_full) begin
              out_valid  <= 1'b1;
              out_status <= sv39pm_pkg::ST_NO_POOL;
              out_leaf   <= '0;
              out_upd    <= 1'b0;
              state      <= S_IDLE;
            end else begin
              // Link a fresh pool page, then clear it.
              page    <= nfree + 1'b1;
              nfree   <= nfree + 1'b1;
              level   <= level - 1'b1;
              clr_idx <= '0;
              state   <= S_CLR;
            end
          end else begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
            if (rd_data[0] && e_ppn != ppn) begin
              out_status <= sv39pm_pkg::ST_CONFLICT;
              out_leaf   <= '0;
              out_upd    <= 1'b0;
            end else begin
              out_status <= sv39pm_pkg::ST_OK;
              out_leaf   <= leaf;
              out_upd    <= rd_data[0];
            end
          end
        end
        S_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (&clr_idx) state <= S_LOOK;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv39_page_map_engine_test.sv =====
// ----------------------------------------------------------------------------
// sv39_page_map_engine_test
// Self-checking bench for the Sv39 page mapper: directed and random map
// requests are driven on the request channel, each transfer is predicted by
// a local copy of the page-table store, and every result transfer is checked
// field by field. Register settings change between phases while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sv39_page_map_engine_test;
  import sv39pm_pkg::*;

  localparam int      POOL_N    = POOL_PAGES_DEF;
  localparam longint  VPN_LIMIT = longint'(1) << (VA_BITS_DEF - 12);
  localparam int      LIMIT     = 400000;
  localparam logic [PPN_W-1:0] PPN_MAX = '1;

  typedef struct packed {
    logic [VPN_W-1:0] virt_page;
    logic [PPN_W-1:0] phys_page;
    logic [2:0]       prot_bits;
    logic             user_access;
  } map_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [ENTRY_W-1:0] leaf_entry;
    logic               perm_updated;
  } map_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  sv39pm_req_if req_ch ();
  sv39pm_rsp_if rsp_ch ();

  sv39_page_map_engine dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req(req_ch.sink), .rsp(rsp_ch.source)
  );

  always #5 clk = ~clk;

  // Local copy of the table store and register shadows.
  logic [ENTRY_W-1:0] tables [0:(1+POOL_N)*512-1];
  int                 pages_used = 0;
  logic [PPN_W-1:0]   root_ppn = '0;
  logic [PPN_W-1:0]   pool_ppn = '0;

  map_req_t pending_reqs[$];
  map_rsp_t expected_rsps[$];
  int  errors = 0;
  int  cycles = 0;
  int  n_acc = 0;
  int  status_seen [0:7];
  int  updates_seen = 0;
  bit  quiet = 1'b0;

  task automatic report(input string what, input longint got, input longint want);
    $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  // Predicts the result of one map request and updates the local store.
  function automatic map_rsp_t map_page(input map_req_t r);
    map_rsp_t           res;
    int                 pg;
    int                 slot;
    logic [ENTRY_W-1:0] ent;
    logic [PPN_W-1:0]   k;
    logic [7:0]         fl;
    res = '0;
    if (root_ppn == '0) begin
      res.status = ST_NO_ROOT;
      return res;
    end
    if (longint'(r.virt_page) >= VPN_LIMIT) begin
      res.status = ST_TOO_HIGH;
      return res;
    end
    pg = 0;
    for (int lvl = 2; lvl > 0; lvl--) begin
      slot = pg * 512 + int'((r.virt_page >> (9 * lvl)) & 511);
      ent = tables[slot];
      if (ent[0]) begin
        k = ent[ENTRY_W-1:10] - pool_ppn;
        if (k >= PPN_W'(pages_used)) begin
          res.status = ST_NO_POOL;
          return res;
        end
        pg = 1 + int'(k);
      end else begin
        if (pages_used >= POOL_N) begin
          res.status = ST_NO_POOL;
          return res;
        end
        pg = 1 + pages_used;
        for (int i = 0; i < 512; i++) tables[pg*512 + i] = '0;
        tables[slot] = {PPN_W'(pool_ppn + PPN_W'(pages_used)), 10'(F_V)};
        pages_used++;
      end
    end
    // Leaf flags: no protection bit at all still grants read.
    fl = 8'h00;
    if (r.prot_bits[0]) fl |= F_R | F_A;
    if (r.prot_bits[1]) fl |= F_W | F_D;
    if (r.prot_bits[2]) fl |= F_X | F_A;
    if (fl == 8'h00) fl = F_R;
    if (r.user_access) fl |= F_U;
    fl |= F_V;
    slot = pg * 512 + int'(r.virt_page & 511);
    ent = tables[slot];
    if (ent[0]) begin
      if (ent[ENTRY_W-1:10] != r.phys_page) begin
        res.status = ST_CONFLICT;
        return res;
      end
      res.perm_updated = 1'b1;
    end
    tables[slot] = {r.phys_page, 2'b00, fl};
    res.status = ST_OK;
    res.leaf_entry = tables[slot];
    return res;
  endfunction

  // Random request, mostly inside a few hot table regions.
  function automatic map_req_t rand_req();
    map_req_t r;
    int mode;
    logic [8:0] l2;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      r.virt_page = VPN_W'($urandom);
    end else if (mode == 1) begin
      r.virt_page = VPN_W'(VPN_LIMIT + ($urandom % (2**VPN_W - VPN_LIMIT)));
    end else begin
      case ($urandom_range(0, 3))
        0: l2 = 9'h000;
        1: l2 = 9'h0ff;
        2: l2 = 9'h055;
        default: l2 = 9'h0aa;
      endcase
      r.virt_page = {l2, ($urandom_range(0, 1) ? 9'h1ff : 9'h000),
                     ($urandom_range(0, 4) != 0 ? 9'($urandom_range(0, 15))
                                                : 9'($urandom))};
    end
    if ($urandom_range(0, 1))
      r.phys_page = PPN_W'(r.virt_page) * 3;
    else
      r.phys_page = {12'($urandom), 32'($urandom)};
    r.prot_bits = 3'($urandom);
    r.user_access = 1'($urandom);
    return r;
  endfunction

  function automatic map_req_t mk(input logic [VPN_W-1:0] v, input logic [PPN_W-1:0] p,
                                  input logic [2:0] pr, input logic u);
    map_req_t r;
    r.virt_page = v;
    r.phys_page = p;
    r.prot_bits = pr;
    r.user_access = u;
    return r;
  endfunction

  // Request driver with random idle bursts.
  int req_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.virt_page <= '0;
      req_ch.phys_page <= '0;
      req_ch.prot_bits <= '0;
      req_ch.user_access <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (req_gap > 0) begin
        req_gap <= req_gap - 1;
        req_ch.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        req_gap <= $urandom_range(0, 3);
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        map_req_t r;
        r = pending_reqs.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.virt_page <= r.virt_page;
        req_ch.phys_page <= r.phys_page;
        req_ch.prot_bits <= r.prot_bits;
        req_ch.user_access <= r.user_access;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // One long hold-off on the result side, so that requests back up.
  int  hold_left = 0;
  bit  held_once = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!held_once && n_acc == 300) begin
      hold_left <= 250;
      held_once <= 1'b1;
    end
  end

  // Result-side ready with random stall bursts.
  int rsp_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
    end else if (rsp_gap > 0) begin
      rsp_gap <= rsp_gap - 1;
      rsp_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      rsp_gap <= $urandom_range(0, 3);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Request monitor: predicts each accepted transfer.
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) begin
      expected_rsps.push_back(map_page(mk(req_ch.virt_page, req_ch.phys_page,
                                          req_ch.prot_bits, req_ch.user_access)));
      n_acc <= n_acc + 1;
    end
  end

  // Result monitor: checks each result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      map_rsp_t want;
      if (expected_rsps.size() == 0) begin
        report("unexpected result status", rsp_ch.status, 0);
      end else begin
        want = expected_rsps.pop_front();
        if (rsp_ch.status !== want.status)
          report("status", rsp_ch.status, want.status);
        if (rsp_ch.leaf_entry !== want.leaf_entry)
          report("leaf_entry", rsp_ch.leaf_entry, want.leaf_entry);
        if (rsp_ch.perm_updated !== want.perm_updated)
          report("perm_updated", rsp_ch.perm_updated, want.perm_updated);
        status_seen[want.status]++;
        if (want.perm_updated) updates_seen++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic reg_write(input logic reg_sel, input logic [DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({reg_sel, 3'b000});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_sel == REG_ROOT) root_ppn = value[PPN_W-1:0];
    else pool_ppn = value[PPN_W-1:0];
  endtask

  // Waits until every queued request has its result back.
  task automatic drain();
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_ch.valid)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    foreach (tables[i]) tables[i] = '0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // No root table yet: every request is rejected.
    reg_write(REG_POOL, 64'(PPN_MAX - 2));
    for (int i = 0; i < 5; i++) pending_reqs.push_back(rand_req());
    drain();

    // Directed: field extremes, all protections, remap, conflict, range edge.
    reg_write(REG_ROOT, 64'd5);
    pending_reqs.push_back(mk(VPN_W'(VPN_LIMIT - 1), PPN_MAX, 3'd7, 1'b1));
    pending_reqs.push_back(mk(VPN_W'(VPN_LIMIT), 44'd1, 3'd1, 1'b0));
    pending_reqs.push_back(mk('1, 44'd1, 3'd1, 1'b0));
    for (int p = 0; p < 8; p++)
      pending_reqs.push_back(mk(VPN_W'(p), 44'd0, 3'(p), 1'(p)));
    pending_reqs.push_back(mk(VPN_W'(3), 44'd0, 3'd6, 1'b1));
    pending_reqs.push_back(mk(VPN_W'(3), 44'h123, 3'd1, 1'b0));
    pending_reqs.push_back(mk(VPN_W'(VPN_LIMIT - 1), PPN_MAX, 3'd0, 1'b0));
    pending_reqs.push_back(mk(VPN_W'(VPN_LIMIT - 1), 44'd0, 3'd2, 1'b0));
    for (int i = 0; i < 650; i++) pending_reqs.push_back(rand_req());
    drain();

    // Moved pool base: existing links no longer point into the pool.
    reg_write(REG_POOL, 64'd0);
    for (int i = 0; i < 60; i++) pending_reqs.push_back(rand_req());
    drain();

    // Original pool base back, widest root value, no idling at all.
    reg_write(REG_POOL, 64'(PPN_MAX - 2));
    reg_write(REG_ROOT, '1);
    quiet = 1'b1;
    for (int i = 0; i < 320; i++) pending_reqs.push_back(rand_req());
    drain();
    repeat (20) @(posedge clk);

    $display("Checked %0d requests: ok %0d (rewrites %0d), no root %0d, too high %0d,",
             n_acc, status_seen[ST_OK], updates_seen, status_seen[ST_NO_ROOT],
             status_seen[ST_TOO_HIGH]);
    $display("pool exhausted or stray link %0d, conflict %0d, pool pages taken %0d.",
             status_seen[ST_NO_POOL], status_seen[ST_CONFLICT], pages_used);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/sv39pm_pkg.sv
rtl/core/sv39pm_if.sv
rtl/core/sv39pm_table_mem.sv
rtl/core/sv39_page_map_engine.sv
tb/sv39_page_map_engine_test.sv
